FILE: rtl/core/smpq_pkg.sv
`timescale 1ns / 1ps
package smpq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Request modes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  prio;
    logic [31:0] entry_key;
    logic [7:0]  age_value;
    logic [7:0]  job_code;
  } req_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_prio;
    logic [31:0] out_key;
    logic [7:0]  out_age;
    logic [7:0]  out_job;
    logic        now_empty;
    logic        now_full;
    logic        op_failed;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  prio;
    logic [31:0] key;
    logic [7:0]  age;
    logic [7:0]  job;
  } cell_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rsp_busy;
  } dp_status_t;

endpackage

FILE: rtl/core/smpq_ctrl.sv
`timescale 1ns / 1ps
module smpq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  logic                   rsp_ready,
  input  smpq_pkg::dp_status_t   status,
  output smpq_pkg::ctrl_cmd_t    cmd
);
  import smpq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic slot_free;

  // Output slot is free when empty or being drained this cycle
  assign slot_free = !status.rsp_busy || rsp_ready;

  assign req_ready = (state == ST_IDLE);
  assign cmd.load  = (state == ST_IDLE) && req_valid;
  assign cmd.exec  = (state == ST_EXEC) && slot_free;

  // Advance between capture and execute
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/smpq_datapath.sv
`timescale 1ns / 1ps
module smpq_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  smpq_pkg::ctrl_cmd_t    cmd,
  input  smpq_pkg::req_t         req,
  input  logic                   rsp_ready,
  output smpq_pkg::dp_status_t   status,
  output logic                   rsp_valid,
  output smpq_pkg::rsp_t         rsp
);
  import smpq_pkg::*;

  req_t              cur;
  cell_t             cells      [QUEUE_DEPTH];
  cell_t             cells_next [QUEUE_DEPTH];
  cell_t             from_below [QUEUE_DEPTH];
  cell_t             from_above [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] le;
  logic [QUEUE_DEPTH-1:0] le_prev;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  cell_t             fresh;
  logic              is_full;
  logic              no_entries;
  logic              failed;
  rsp_t              rsp_next;

  assign fresh      = '{prio: cur.prio, key: cur.entry_key, age: cur.age_value,
                        job: cur.job_code};
  assign is_full    = (count == CNT_W'(QUEUE_DEPTH));
  assign no_entries = (count == '0);
  assign failed     = (cur.mode == MODE_INSERT) ? is_full : no_entries;

  // Hold the captured request
  always_ff @(posedge clk) begin
    if (cmd.load) cur <= req;
  end

  // Per-cell compare and neighbor taps
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      le[i] = (CNT_W'(i) < count) && (cells[i].prio <= cur.prio);
    end
    le_prev[0]    = 1'b1;
    from_below[0] = fresh;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      le_prev[i]    = le[i-1];
      from_below[i] = cells[i-1];
    end
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      from_above[i] = cells[i+1];
    end
    from_above[QUEUE_DEPTH-1] = cells[QUEUE_DEPTH-1];
  end

  // Select each cell's next content: keep, drop in, shift down or shift up
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cells_next[i] = cells[i];
      if (!failed) begin
        if (cur.mode == MODE_INSERT) begin
          if (le[i] || (CNT_W'(i) > count)) begin
            cells_next[i] = cells[i];
          end else if (le_prev[i]) begin
            cells_next[i] = fresh;
          end else begin
            cells_next[i] = from_below[i];
          end
        end else begin
          cells_next[i] = from_above[i];
        end
      end
    end
  end

  // Next count and result
  always_comb begin
    count_next = count;
    if (!failed) begin
      if (cur.mode == MODE_INSERT) count_next = count + CNT_W'(1);
      else                         count_next = count - CNT_W'(1);
    end
    rsp_next           = '0;
    rsp_next.op_failed = failed;
    rsp_next.now_empty = (count_next == '0);
    rsp_next.now_full  = (count_next == CNT_W'(QUEUE_DEPTH));
    if (cur.mode == MODE_REMOVE && !failed) begin
      rsp_next.out_valid = 1'b1;
      rsp_next.out_prio  = cells[0].prio;
      rsp_next.out_key   = cells[0].key;
      rsp_next.out_age   = cells[0].age;
      rsp_next.out_job   = cells[0].job;
    end
  end

  // Update queue storage
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) cells[i] <= cells_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  // Output register: load on execute, drop when taken
  always_ff @(posedge clk) begin
    if (cmd.exec) rsp <= rsp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.exec) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign status.rsp_busy = rsp_valid;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_exec_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> rsp_valid)
    else $error("execute did not load a response");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> (!rsp_valid || rsp_ready))
    else $error("execute overwrote a pending response");

  a_empty_remove: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && cur.mode == MODE_REMOVE && no_entries
    |=> rsp.op_failed && !rsp.out_valid && count == '0)
    else $error("remove from empty queue not flagged");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && cur.mode == MODE_INSERT && !is_full
    |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the queue");
`endif

endmodule

FILE: rtl/core/stable_min_priority_queue_unit.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  smpq_pkg::req_t (mode, prio, key, age, job)
// rsp      out        rsp_valid / rsp_ready  smpq_pkg::rsp_t (removed entry and flags)
//
// Each request is captured in the idle state; the execute state then updates the sorted
// shift-register cells in parallel and loads the response register.
// A new request is taken while the previous response still waits.
// A stalled response holds the execute step, so at most one request waits behind it.
// Synchronous active-high reset empties the queue; cell contents are not cleared.
module stable_min_priority_queue_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  smpq_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output smpq_pkg::rsp_t  rsp
);
  import smpq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  smpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  smpq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .rsp_ready (rsp_ready),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule
